@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/grc_pkg.sv @@
// Types, tables and helper functions for the grid raycast pixel shader.
// Depends on nothing; used by the front, back and top modules of the block.
package grc_pkg;

    localparam int FOV_STEPS = 20;

    // One classified request passed from the front part to the back part.
    typedef struct packed {
        logic       is_tick;
        logic [5:0] ang;
        logic [6:0] row;
        logic [5:0] turn;
        logic [1:0] mv;
    } grc_req_t;

    function automatic logic is_wall(input logic [7:0] x, input logic [7:0] y);
        logic [3:0] cx;
        logic [3:0] cy;
        logic       w;
        cx = x[7:4];
        cy = y[7:4];
        w = (cx == 4'd0) || (cx == 4'd15) || (cy == 4'd0) || (cy == 4'd15);
        if ((cy == 4'd3 || cy == 4'd4) && (cx == 4'd4 || cx == 4'd5 || cx == 4'd11
            || cx == 4'd12))
        begin
            w = 1'b1;
        end
        if ((cy == 4'd7 || cy == 4'd8) && (cx == 4'd7 || cx == 4'd8))
        begin
            w = 1'b1;
        end
        if ((cy == 4'd10 || cy == 4'd11) && (cx == 4'd3 || cx == 4'd4))
        begin
            w = 1'b1;
        end
        return w;
    endfunction

    // Quarter wave of the step vector; sin(a) = cos(a - 16).
    function automatic logic [7:0] cos_step(input logic [5:0] a);
        logic [4:0] q;
        logic [3:0] i;
        logic [4:0] m;
        q = 5'd0;
        i = a[3:0];
        if (a[4])
        begin
            i = 4'd0 - a[3:0];
        end
        case (i)
            4'd0: m = 5'd16;  4'd1: m = 5'd16;  4'd2: m = 5'd16;  4'd3: m = 5'd15;
            4'd4: m = 5'd15;  4'd5: m = 5'd14;  4'd6: m = 5'd13;  4'd7: m = 5'd12;
            4'd8: m = 5'd11;  4'd9: m = 5'd10;  4'd10: m = 5'd9;  4'd11: m = 5'd8;
            4'd12: m = 5'd6;  4'd13: m = 5'd5;  4'd14: m = 5'd3;  4'd15: m = 5'd2;
            default: m = 5'd0;
        endcase
        if (a[4] && a[3:0] == 4'd0)
        begin
            m = 5'd0;
        end
        q = m;
        // Quadrants 1 and 2 are negative.
        if (a[5] ^ a[4])
        begin
            return 8'd0 - {3'd0, q};
        end
        return {3'd0, q};
    endfunction

    function automatic logic [7:0] sin_step(input logic [5:0] a);
        return cos_step(a - 6'd16);
    endfunction

    function automatic logic [5:0] half_height(input logic [2:0] d);
        case (d)
            3'd0: return 6'd4;
            3'd1: return 6'd40;
            3'd2: return 6'd20;
            3'd3: return 6'd13;
            3'd4: return 6'd10;
            default: return 6'd4;
        endcase
    endfunction

    function automatic logic [10:0] inv_span(input logic [2:0] d);
        case (d)
            3'd0: return 11'd256;
            3'd1: return 11'd26;
            3'd2: return 11'd51;
            3'd3: return 11'd79;
            3'd4: return 11'd102;
            default: return 11'd256;
        endcase
    endfunction

    function automatic logic [3:0] brick(input logic dark, input logic [2:0] v,
                                         input logic [2:0] u);
        logic mortar;
        mortar = (v == 3'd3) || (v == 3'd7) || (v == 3'd1 && (u == 3'd1 || u == 3'd6))
            || (v == 3'd5 && u == 3'd3);
        case ({dark, mortar})
            2'b00: return 4'd3;
            2'b01: return 4'd14;
            2'b10: return 4'd5;
            2'b11: return 4'd7;
            default: return 4'd3;
        endcase
    endfunction

endpackage

@@ rtl/grc_front.sv @@
// Front part: accepts requests, maps the column to a ray angle, classifies.
// Depends on grc_pkg.
module grc_front #(
    parameter int SCREEN_COLUMNS = 160
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             req_type,
    input  logic [7:0]       pixel_col,
    input  logic [6:0]       pixel_row,
    input  logic [5:0]       turn_amount,
    input  logic [1:0]       move_code,
    output logic             q_valid,
    input  logic             q_stall,
    output grc_pkg::grc_req_t q_req
);
    import grc_pkg::*;

    // col * 20 / SCREEN_COLUMNS, modulo 64, through a 256-entry constant table.
    logic [5:0] col_ang_tab [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_col_ang
        assign col_ang_tab[g] = 6'((g * FOV_STEPS / SCREEN_COLUMNS) % 64);
    end

    logic     full_reg;
    logic     full_next;
    grc_req_t req_reg;
    grc_req_t req_next;

    assign in_stall = full_reg && q_stall;
    assign q_valid = full_reg;
    assign q_req = req_reg;

    always_comb
    begin
        full_next = full_reg;
        req_next = req_reg;
        if (!in_stall)
        begin
            full_next = in_valid;
            req_next.is_tick = req_type;
            req_next.ang = col_ang_tab[pixel_col];
            req_next.row = pixel_row;
            req_next.turn = turn_amount;
            req_next.mv = move_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end
endmodule

@@ rtl/grc_back.sv @@
// Back part: updates the pose for ticks and shades pixels in a two-stage pipe.
// Depends on grc_pkg.
module grc_back #(
    parameter int HORIZON_ROW = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_stall,
    input  grc_pkg::grc_req_t q_req,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [3:0]       colour
);
    import grc_pkg::*;

    logic [7:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [5:0] head_reg, head_next;

    // Stage 1 registers: ray result for one pixel.
    logic       s1_valid_reg, s1_valid_next;
    logic [2:0] s1_dist_reg;
    logic [2:0] s1_u_reg;
    logic [7:0] s1_rel_reg;
    logic       s1_ceil_reg, s1_floor_reg;
    // Stage 2: output register.
    logic       s2_valid_reg, s2_valid_next;
    logic [3:0] s2_colour_reg;

    logic       adv1;
    logic       adv0;
    logic [5:0] ang;
    logic [7:0] dx, dy;
    logic [7:0] rx [1:4];
    logic [7:0] ry [1:4];
    logic [2:0] hit_dist;
    logic [7:0] hx, hy;
    logic [5:0] h;
    logic [7:0] top, bot;
    logic [5:0] nh;
    logic [7:0] tx, ty, nx, ny;
    logic [18:0] prod;

    assign adv1 = !s2_valid_reg || !out_stall;
    assign adv0 = !s1_valid_reg || adv1;
    assign q_stall = !adv0;

    always_comb
    begin
        ang = q_req.ang + head_reg;
        dx = cos_step(ang);
        dy = sin_step(ang);
        hit_dist = 3'd0;
        hx = pos_x_reg;
        hy = pos_y_reg;
        for (int s = 1; s <= 4; s++)
        begin
            rx[s] = pos_x_reg + 8'(s) * dx;
            ry[s] = pos_y_reg + 8'(s) * dy;
        end
        for (int s = 4; s >= 1; s--)
        begin
            if (is_wall(rx[s], ry[s]))
            begin
                hit_dist = 3'(s);
                hx = rx[s];
                hy = ry[s];
            end
        end
        h = half_height(hit_dist);
        top = 8'(HORIZON_ROW) - {2'd0, h};
        bot = 8'(HORIZON_ROW) + {2'd0, h};
    end

    always_comb
    begin
        nh = head_reg + q_req.turn;
        tx = cos_step(nh);
        ty = sin_step(nh);
        nx = pos_x_reg;
        ny = pos_y_reg;
        if (q_req.mv == 2'd1)
        begin
            nx = pos_x_reg + tx;
            ny = pos_y_reg + ty;
        end
        else if (q_req.mv == 2'd2)
        begin
            nx = pos_x_reg - tx;
            ny = pos_y_reg - ty;
        end
        head_next = head_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (q_valid && adv0 && q_req.is_tick)
        begin
            head_next = nh;
            if (!is_wall(nx, ny))
            begin
                pos_x_next = nx;
                pos_y_next = ny;
            end
        end
        s1_valid_next = s1_valid_reg;
        if (adv0)
        begin
            s1_valid_next = q_valid && !q_req.is_tick;
        end
        s2_valid_next = s2_valid_reg;
        if (adv1)
        begin
            s2_valid_next = s1_valid_reg;
        end
        prod = 19'(s1_rel_reg) * 19'(inv_span(s1_dist_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= 8'd128;
            pos_y_reg <= 8'd128;
            head_reg <= 6'd0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            head_reg <= head_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            s1_dist_reg <= hit_dist;
            s1_u_reg <= 3'(hx[7:1] + hy[7:1]);
            s1_rel_reg <= {1'b0, q_req.row} - top;
            s1_ceil_reg <= {1'b0, q_req.row} < top;
            s1_floor_reg <= {1'b0, q_req.row} > bot;
        end
        if (adv1)
        begin
            if (s1_ceil_reg)
            begin
                s2_colour_reg <= 4'd1;
            end
            else if (s1_floor_reg)
            begin
                s2_colour_reg <= 4'd2;
            end
            else
            begin
                s2_colour_reg <= brick(s1_dist_reg >= 3'd3, prod[10:8], s1_u_reg);
            end
        end
    end

    assign out_valid = s2_valid_reg;
    assign colour = s2_colour_reg;
endmodule

@@ rtl/grid_raycast_pixel_shader_top.sv @@
// Grid raycast pixel shader: pixel requests give a colour, ticks move the player.
// A pixel request passes the front register, the ray stage and the output register.
// Throughput: one request per cycle; the front register, the ray stage and the
// output register form the short queue, and each stage holds under a stall.
// Reset (asynchronous, rst_n low) sets the pose to x = y = 128, heading 0,
// and empties every stage.
module grid_raycast_pixel_shader_top #(
    parameter int SCREEN_COLUMNS = 160,
    parameter int HORIZON_ROW = 50
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] pixel_col,
    input  logic [6:0] pixel_row,
    input  logic [5:0] turn_amount,
    input  logic [1:0] move_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] colour
);
    import grc_pkg::*;

    // The front register is the queue between the two parts; the ray angle
    // from the column is looked up there, and the heading is added behind it
    // so that a tick ahead of a pixel always takes effect first.
    logic     q_valid;
    logic     q_stall;
    grc_req_t q_req;

    grc_front #(.SCREEN_COLUMNS(SCREEN_COLUMNS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pixel_col(pixel_col), .pixel_row(pixel_row),
        .turn_amount(turn_amount), .move_code(move_code),
        .q_valid(q_valid), .q_stall(q_stall), .q_req(q_req)
    );

    // The back part applies ticks to the pose and shades pixel requests.
    grc_back #(.HORIZON_ROW(HORIZON_ROW)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_stall(q_stall),
        .q_req(q_req), .out_valid(out_valid),
        .out_stall(out_stall), .colour(colour)
    );
endmodule

@@ rtl/grc_checker.sv @@
// Port-level checker for the grid raycast pixel shader, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module grc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       req_type,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] colour
);
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(colour), "stalled result changed")
    `CHK_IMPLY(a_no_colour0, clk, rst_n, out_valid, colour != 4'd0, "colour zero is never produced")
    `CHK_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(req_type), "stalled request changed")
    `CHK_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled with output free")
endmodule

bind grid_raycast_pixel_shader_top grc_checker u_grc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .out_valid(out_valid), .out_stall(out_stall),
    .colour(colour)
);

@@ verif/tb_grid_raycast_pixel_shader_top.sv @@
// Self-checking testbench for the grid raycast pixel shader top level.
// Depends on grid_raycast_pixel_shader_top; holds its own pose predictor.
module tb_grid_raycast_pixel_shader_top;

    localparam int COLS = 160;
    localparam int HORIZON = 50;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_TICK = 1'b1;
    localparam logic [1:0] MOVE_STAY = 2'd0;
    localparam logic [1:0] MOVE_FWD = 2'd1;
    localparam logic [1:0] MOVE_BACK = 2'd2;
    localparam logic [1:0] MOVE_STAY_ALT = 2'd3;

    // The scoreboard keeps its own pose and the colours still owed by the block.
    class shade_scoreboard;
        logic [7:0] px;
        logic [7:0] py;
        logic [5:0] heading;
        logic [3:0] owed[$];
        int errors;
        int pixels;
        int ticks;
        int blocked;

        function new();
            px = 8'd128;
            py = 8'd128;
            heading = 6'd0;
            errors = 0;
            pixels = 0;
            ticks = 0;
            blocked = 0;
        endfunction

        function bit wall_at(logic [7:0] x, logic [7:0] y);
            logic [3:0] cx;
            logic [3:0] cy;
            cx = x[7:4];
            cy = y[7:4];
            if (cx == 0 || cx == 15 || cy == 0 || cy == 15)
                return 1;
            if ((cy == 3 || cy == 4) && (cx == 4 || cx == 5 || cx == 11 || cx == 12))
                return 1;
            if ((cy == 7 || cy == 8) && (cx == 7 || cx == 8))
                return 1;
            if ((cy == 10 || cy == 11) && (cx == 3 || cx == 4))
                return 1;
            return 0;
        endfunction

        function logic [7:0] cos_vec(logic [5:0] a);
            int mag[16];
            int q;
            int i;
            int v;
            mag = '{16, 16, 16, 15, 15, 14, 13, 12, 11, 10, 9, 8, 6, 5, 3, 2};
            q = a / 16;
            i = a % 16;
            case (q)
                0: v = mag[i];
                1: v = (i == 0) ? 0 : -mag[16 - i];
                2: v = -mag[i];
                default: v = (i == 0) ? 0 : mag[16 - i];
            endcase
            return v[7:0];
        endfunction

        function logic [7:0] sin_vec(logic [5:0] a);
            return cos_vec(a - 6'd16);
        endfunction

        function logic [3:0] texel(bit dark, logic [2:0] v, logic [2:0] u);
            bit mortar;
            mortar = (v == 3) || (v == 7) || (v == 1 && (u == 1 || u == 6))
                || (v == 5 && u == 3);
            if (dark)
                return mortar ? 4'd7 : 4'd5;
            return mortar ? 4'd14 : 4'd3;
        endfunction

        function logic [3:0] shade(logic [7:0] col, logic [6:0] row);
            int hts[5];
            int recip[5];
            logic [5:0] ang;
            logic [7:0] x;
            logic [7:0] y;
            logic [7:0] hx;
            logic [7:0] hy;
            logic [2:0] u;
            logic [2:0] v;
            int hit_step;
            int h;
            int rel;
            hts = '{4, 40, 20, 13, 10};
            recip = '{256, 26, 51, 79, 102};
            ang = 6'((int'(col) * 20) / COLS) + heading;
            x = px;
            y = py;
            hx = px;
            hy = py;
            hit_step = 0;
            for (int s = 1; s <= 4; s++)
            begin
                x = x + cos_vec(ang);
                y = y + sin_vec(ang);
                if (hit_step == 0 && wall_at(x, y))
                begin
                    hit_step = s;
                    hx = x;
                    hy = y;
                end
            end
            h = hts[hit_step];
            u = 3'((hx >> 1) + (hy >> 1));
            rel = int'(row) - (HORIZON - h);
            if (rel < 0)
                return 4'd1;
            if (int'(row) > HORIZON + h)
                return 4'd2;
            v = 3'((rel * recip[hit_step]) >> 8);
            return texel(hit_step >= 3, v, u);
        endfunction

        function void note_request(logic kind, logic [7:0] col, logic [6:0] row,
                                   logic [5:0] turn, logic [1:0] mv);
            logic [7:0] nx;
            logic [7:0] ny;
            if (kind == REQ_PIXEL)
            begin
                owed.push_back(shade(col, row));
                pixels++;
            end
            else
            begin
                ticks++;
                heading = heading + turn;
                nx = px;
                ny = py;
                if (mv == MOVE_FWD)
                begin
                    nx = px + cos_vec(heading);
                    ny = py + sin_vec(heading);
                end
                else if (mv == MOVE_BACK)
                begin
                    nx = px - cos_vec(heading);
                    ny = py - sin_vec(heading);
                end
                if (!wall_at(nx, ny))
                begin
                    px = nx;
                    py = ny;
                end
                else
                    blocked++;
            end
        endfunction

        function void check_colour(logic [3:0] got);
            logic [3:0] want;
            if (owed.size() == 0)
            begin
                $error("colour: no request waiting, got %0d", got);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got !== want)
            begin
                $error("colour: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = 1'b0;
    logic [7:0] pixel_col = 8'd0;
    logic [6:0] pixel_row = 7'd0;
    logic [5:0] turn_amount = 6'd0;
    logic [1:0] move_code = 2'd0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] colour;

    shade_scoreboard board;
    int cycle_count = 0;
    bit quiet_phase = 1'b0;

    always #4 clk = ~clk;

    grid_raycast_pixel_shader_top #(
        .SCREEN_COLUMNS(COLS),
        .HORIZON_ROW(HORIZON)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .pixel_col(pixel_col),
        .pixel_row(pixel_row),
        .turn_amount(turn_amount),
        .move_code(move_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .colour(colour)
    );

    // The run is cut off if the block hangs; this keeps a stuck handshake visible.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiving side stalls for a random number of cycles before each
    // result, except in quiet phases where it takes every colour at once.
    initial
    begin : receiver
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = quiet_phase ? 0 : $urandom_range(0, 11);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid || out_stall)
                @(posedge clk);
            board.check_colour(colour);
        end
    end

    // Sends one request; the payload holds until the edge that accepts it.
    // The gap before the request is drawn in this task, and valid is
    // lowered only when there is a real pause.
    task automatic send_request(logic kind, logic [7:0] col, logic [6:0] row,
                                logic [5:0] turn, logic [1:0] mv);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        pixel_col <= col;
        pixel_row <= row;
        turn_amount <= turn;
        move_code <= mv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(kind, col, row, turn, mv);
    endtask

    task automatic send_pixel(logic [7:0] col, logic [6:0] row);
        send_request(REQ_PIXEL, col, row, 6'($urandom), 2'($urandom));
    endtask

    task automatic send_tick(logic [5:0] turn, logic [1:0] mv);
        send_request(REQ_TICK, 8'($urandom), 7'($urandom), turn, mv);
    endtask

    // Holds the sender off until every owed colour has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.owed.size() != 0)
            @(posedge clk);
    endtask

    // Sweeps one frame column strip: one random column, six random rows from 0 to 99.
    task automatic column_strip();
        logic [7:0] c;
        c = 8'($urandom_range(0, COLS - 1));
        for (int k = 0; k < 6; k++)
            send_pixel(c, 7'($urandom_range(0, 99)));
    endtask

    initial
    begin : stimulus
        int pick;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, both request kinds, every move code,
        // out-of-range columns and rows, and a walk into the wall to check
        // that a blocked step leaves the position alone.
        send_pixel(8'd0, 7'd0);
        send_pixel(8'd159, 7'd99);
        send_pixel(8'd255, 7'd127);
        send_pixel(8'd160, 7'd50);
        send_pixel(8'd80, 7'd10);
        send_pixel(8'd80, 7'd90);
        send_tick(6'd0, MOVE_STAY);
        send_tick(6'd63, MOVE_STAY_ALT);
        send_tick(6'd1, MOVE_FWD);
        for (int k = 0; k < 8; k++)
            send_tick(6'd0, MOVE_FWD);
        send_pixel(8'd0, 7'd45);
        send_pixel(8'd100, 7'd52);
        send_tick(6'd32, MOVE_BACK);
        send_tick(6'd0, MOVE_BACK);
        send_pixel(8'd127, 7'd64);
        send_pixel(8'd128, 7'd63);

        // A pause with nothing in flight, then a burst with no idling.
        drain_results();
        quiet_phase = 1'b1;
        for (int k = 0; k < 40; k++)
            send_pixel(8'($urandom_range(0, 159)), 7'($urandom_range(0, 99)));
        quiet_phase = 1'b0;

        // Random part: mostly walks with rendered strips, plus raw noise.
        for (int k = 0; k < 1300; )
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                send_tick(6'($urandom), 2'($urandom));
                k++;
            end
            else if (pick < 5)
            begin
                column_strip();
                k += 6;
            end
            else if (pick < 9)
            begin
                send_pixel(8'($urandom_range(0, 159)), 7'($urandom_range(0, 99)));
                k++;
            end
            else
            begin
                send_request(1'($urandom), 8'($urandom), 7'($urandom),
                             6'($urandom), 2'($urandom));
                k++;
            end
            if (k % 400 == 399)
                quiet_phase = ~quiet_phase;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d pixel requests and %0d ticks, %0d steps blocked by walls.",
                 board.pixels, board.ticks, board.blocked);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/grc_pkg.sv
rtl/grc_front.sv
rtl/grc_back.sv
rtl/grid_raycast_pixel_shader_top.sv
rtl/grc_checker.sv
verif/tb_grid_raycast_pixel_shader_top.sv
